/* rtl/kt_pkg.sv */
// Shared types and constants for the keyed volume table.
package kt_pkg;

    localparam int CAPACITY  = 128;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int DIM_W     = 16;
    localparam int AREA_W    = 2 * DIM_W;
    localparam int VOL_W     = 3 * DIM_W;
    localparam int OUT_CNT_W = 8;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_INSERT  = 2'd1,
        MODE_REM_KEY = 2'd2,
        MODE_REM_MIN = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_MOVE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] slot;
    } t_scan;

endpackage

/* rtl/kt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kt_vol.sv */
// Two-stage volume multiplier: length * width, then * height.
module kt_vol (
    input  logic                       i_clk,
    input  logic [kt_pkg::DIM_W-1:0]   i_len,
    input  logic [kt_pkg::DIM_W-1:0]   i_wid,
    input  logic [kt_pkg::DIM_W-1:0]   i_hgt,
    output logic [kt_pkg::VOL_W-1:0]   o_vol
);
    import kt_pkg::*;

    logic [AREA_W-1:0] r_area;
    logic [DIM_W-1:0]  r_hgt;
    logic [VOL_W-1:0]  r_vol;

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(i_len) * AREA_W'(i_wid);
        r_hgt  <= i_hgt;
        r_vol  <= VOL_W'(r_area) * VOL_W'(r_hgt);
    end

    assign o_vol = r_vol;

endmodule

/* rtl/kt_scan.sv */
// Shared compare unit: key match or running minimum over streamed entries.
module kt_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic                      i_vld,
    input  logic                      i_is_min,
    input  logic [kt_pkg::IDX_W-1:0]  i_idx,
    input  logic [kt_pkg::KEY_W-1:0]  i_key,
    input  logic [kt_pkg::KEY_W-1:0]  i_rd_key,
    input  logic [kt_pkg::VOL_W-1:0]  i_rd_vol,
    output kt_pkg::t_scan             o_scan
);
    import kt_pkg::*;

    logic             r_found, n_found;
    logic [IDX_W-1:0] r_slot,  n_slot;
    logic [VOL_W-1:0] r_best,  n_best;

    always_comb begin
        n_found = r_found;
        n_slot  = r_slot;
        n_best  = r_best;
        if (i_clr) begin
            n_found = 1'b0;
        end else if (i_vld) begin
            if (i_is_min) begin
                // first entry seeds the minimum; strict less keeps lowest index
                if (i_idx == '0 || i_rd_vol < r_best) begin
                    n_found = 1'b1;
                    n_slot  = i_idx;
                    n_best  = i_rd_vol;
                end
            end else if (!r_found && i_rd_key == i_key) begin
                n_found = 1'b1;
                n_slot  = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
        r_slot <= n_slot;
        r_best <= n_best;
    end

    assign o_scan.found = r_found;
    assign o_scan.slot  = r_slot;

endmodule

/* rtl/keyed_table_with_min_volume_removal_top.sv */
// Top level of the keyed volume table: sequencer, stores and result port.
//
// Usage: drive i_mode, i_key and the three Q8.8 dimensions and raise start.
// The item is taken at a rising edge where start is high and busy is low;
// busy then stays high until the result has been shown. Modes: clear,
// insert (fails on a duplicate key or a full table), remove by key, and
// remove the entry of smallest volume (lowest index wins ties). A removal
// moves the last entry into the freed slot.
//
// The result (o_success, o_entry_count) is on the ports for exactly one
// cycle, marked by o_valid. The receiver cannot stall; it must take it.
//
// Clear, and remove smallest on an empty table, answer without a scan. Other
// modes walk the held entries through one shared compare unit, one entry per
// cycle out of the key and volume RAMs; a key search stops feeding entries
// once a key has hit. A successful item then passes ST_LAST and ST_MOVE,
// where the store is updated, before the result. The block returns to idle
// after each result before it takes the next item. Reset only zeroes the
// count; no clearing pass runs.
module keyed_table_with_min_volume_removal_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic [kt_pkg::KEY_W-1:0]      i_key,
    input  logic [kt_pkg::DIM_W-1:0]      i_length_dim,
    input  logic [kt_pkg::DIM_W-1:0]      i_width_dim,
    input  logic [kt_pkg::DIM_W-1:0]      i_height_dim,
    output logic                          o_valid,
    output logic                          o_success,
    output logic [kt_pkg::OUT_CNT_W-1:0]  o_entry_count
);
    import kt_pkg::*;

    t_state           r_state, n_state;
    t_mode            r_mode,  n_mode;
    logic [KEY_W-1:0] r_key,   n_key;
    logic [DIM_W-1:0] r_len,   n_len;
    logic [DIM_W-1:0] r_wid,   n_wid;
    logic [DIM_W-1:0] r_hgt,   n_hgt;
    logic [CNT_W-1:0] r_fill,  n_fill;
    logic [CNT_W-1:0] r_addr,  n_addr;
    logic             r_ok,    n_ok;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;

    logic             accept;
    logic             key_mode;
    logic             issue;
    logic             scan_done;
    logic             scan_ok;
    logic             scan_clr;
    logic [CNT_W-1:0] last_cnt;
    logic [IDX_W-1:0] last_idx;
    logic             slot_moves;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [KEY_W-1:0] wr_key;
    logic [VOL_W-1:0] wr_vol;
    logic [KEY_W-1:0] rd_key;
    logic [VOL_W-1:0] rd_vol;
    logic [VOL_W-1:0] new_vol;
    t_scan            scan;

    assign accept     = start && (r_state == ST_IDLE);
    assign key_mode   = (r_mode != MODE_REM_MIN);
    assign last_cnt   = r_fill - CNT_W'(1);
    assign last_idx   = last_cnt[IDX_W-1:0];
    assign slot_moves = (CNT_W'(scan.slot) != last_cnt);

    // Stream entries below the count; stop feeding once a key has hit.
    assign issue     = (r_state == ST_SCAN) && (r_addr < r_fill)
                       && !(key_mode && scan.found);
    assign scan_done = (r_state == ST_SCAN) && !issue && !r_cmp_vld;
    assign scan_clr  = accept;

    always_comb begin
        case (r_mode)
            MODE_INSERT:  scan_ok = !scan.found && (r_fill < CNT_W'(CAPACITY));
            MODE_REM_KEY: scan_ok = scan.found;
            MODE_REM_MIN: scan_ok = scan.found;
            default:      scan_ok = 1'b1;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (t_mode'(i_mode) == MODE_CLEAR) begin
                        n_state = ST_RESP;
                    end else if (t_mode'(i_mode) == MODE_REM_MIN && r_fill == '0) begin
                        n_state = ST_RESP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = scan_ok ? ST_LAST : ST_RESP;
                end
            end
            ST_LAST: n_state = ST_MOVE;
            ST_MOVE: n_state = ST_RESP;
            ST_RESP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and store control
    always_comb begin
        n_mode    = r_mode;
        n_key     = r_key;
        n_len     = r_len;
        n_wid     = r_wid;
        n_hgt     = r_hgt;
        n_fill    = r_fill;
        n_addr    = r_addr;
        n_ok      = r_ok;
        ram_we    = 1'b0;
        ram_waddr = scan.slot;
        ram_raddr = r_addr[IDX_W-1:0];
        wr_key    = rd_key;
        wr_vol    = rd_vol;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_mode = t_mode'(i_mode);
                    n_key  = i_key;
                    n_len  = i_length_dim;
                    n_wid  = i_width_dim;
                    n_hgt  = i_height_dim;
                    n_addr = '0;
                    n_ok   = (t_mode'(i_mode) == MODE_CLEAR);
                    if (t_mode'(i_mode) == MODE_CLEAR) begin
                        n_fill = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    n_addr = r_addr + CNT_W'(1);
                end
                if (scan_done) begin
                    n_ok = scan_ok;
                end
            end
            ST_LAST: begin
                // fetch the tail entry that fills the freed slot
                ram_raddr = last_idx;
            end
            ST_MOVE: begin
                if (r_mode == MODE_INSERT) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_fill[IDX_W-1:0];
                    wr_key    = r_key;
                    wr_vol    = new_vol;
                    n_fill    = r_fill + CNT_W'(1);
                end else begin
                    ram_we = slot_moves;
                    n_fill = last_cnt;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_ok      <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_ok      <= n_ok;
            r_cmp_vld <= issue;
        end
        r_mode    <= n_mode;
        r_key     <= n_key;
        r_len     <= n_len;
        r_wid     <= n_wid;
        r_hgt     <= n_hgt;
        r_addr    <= n_addr;
        r_cmp_idx <= r_addr[IDX_W-1:0];
    end

    kt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_key),
        .i_raddr (ram_raddr),
        .o_rdata (rd_key)
    );

    kt_ram #(
        .WIDTH (VOL_W),
        .DEPTH (CAPACITY)
    ) u_vol_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_vol),
        .i_raddr (ram_raddr),
        .o_rdata (rd_vol)
    );

    kt_vol u_vol (
        .i_clk (i_clk),
        .i_len (r_len),
        .i_wid (r_wid),
        .i_hgt (r_hgt),
        .o_vol (new_vol)
    );

    kt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (scan_clr),
        .i_vld    (r_cmp_vld),
        .i_is_min (!key_mode),
        .i_idx    (r_cmp_idx),
        .i_key    (r_key),
        .i_rd_key (rd_key),
        .i_rd_vol (rd_vol),
        .o_scan   (scan)
    );

    // Outputs
    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = (r_state == ST_RESP);
    assign o_success     = r_ok;
    assign o_entry_count = OUT_CNT_W'(r_fill);

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("not busy after taking an item");

    a_fail_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_success) |-> $stable(r_fill))
        else $error("failed operation changed the count");

    a_write_in_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_MOVE && r_ok))
        else $error("store written outside a successful update");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the keyed volume table: directed, full-table and random items.
`timescale 1ns / 1ps

module tb_top;
    import kt_pkg::*;

    // One result as the block reports it.
    typedef struct packed {
        logic                 success;
        logic [OUT_CNT_W-1:0] entry_count;
    } t_outcome;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 start        = 1'b0;
    logic [1:0]           i_mode       = MODE_CLEAR;
    logic [KEY_W-1:0]     i_key        = '0;
    logic [DIM_W-1:0]     i_length_dim = '0;
    logic [DIM_W-1:0]     i_width_dim  = '0;
    logic [DIM_W-1:0]     i_height_dim = '0;
    logic                 busy;
    logic                 o_valid;
    logic                 o_success;
    logic [OUT_CNT_W-1:0] o_entry_count;

    // Shadow copy of the table, updated as each item is accepted.
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    logic [VOL_W-1:0] shadow_vols [CAPACITY];
    int unsigned      shadow_fill = 0;

    // Outcomes of accepted items whose results have not arrived yet, oldest first.
    t_outcome    pending_outcomes[$];
    int unsigned mismatch_count = 0;

    // When set, the sender puts no gap between items.
    bit          back_to_back = 1'b0;

    keyed_table_with_min_volume_removal_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_length_dim  (i_length_dim),
        .i_width_dim   (i_width_dim),
        .i_height_dim  (i_height_dim),
        .o_valid       (o_valid),
        .o_success     (o_success),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Bound the run well beyond the slowest legal pace of every item.
    initial begin
        #10_000_000;
        $display("timeout: %0d results still outstanding", pending_outcomes.size());
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Linear search of the shadow table; -1 when the key is absent.
    function automatic int find_shadow_slot(input logic [KEY_W-1:0] key);
        for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_keys[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Drop one entry: move the last entry into the hole, then shrink.
    function automatic void drop_shadow_slot(input int slot);
        int last;
        last = shadow_fill - 1;
        if (slot != last) begin
            shadow_keys[slot] = shadow_keys[last];
            shadow_vols[slot] = shadow_vols[last];
        end
        shadow_fill = last;
    endfunction

    // Apply one item to the shadow table and return the outcome it must produce.
    function automatic t_outcome apply_table_op(
        input t_mode            mode,
        input logic [KEY_W-1:0] key,
        input logic [DIM_W-1:0] len,
        input logic [DIM_W-1:0] wid,
        input logic [DIM_W-1:0] hgt
    );
        int               pos;
        logic             ok;
        logic [VOL_W-1:0] vol;
        logic [VOL_W-1:0] best;
        t_outcome         res;
        ok = 1'b0;
        case (mode)
            MODE_CLEAR: begin
                shadow_fill = 0;
                ok = 1'b1;
            end
            MODE_INSERT: begin
                // Reject a duplicate key and an insert into a full table.
                if (find_shadow_slot(key) < 0 && shadow_fill < CAPACITY) begin
                    vol = VOL_W'(len);
                    vol = vol * wid;
                    vol = vol * hgt;
                    shadow_keys[shadow_fill] = key;
                    shadow_vols[shadow_fill] = vol;
                    shadow_fill++;
                    ok = 1'b1;
                end
            end
            MODE_REM_KEY: begin
                pos = find_shadow_slot(key);
                if (pos >= 0) begin
                    drop_shadow_slot(pos);
                    ok = 1'b1;
                end
            end
            default: begin
                // Strict less-than keeps the lowest index on equal volumes.
                if (shadow_fill > 0) begin
                    pos  = 0;
                    best = shadow_vols[0];
                    for (int i = 1; i < shadow_fill; i++) begin
                        if (shadow_vols[i] < best) begin
                            best = shadow_vols[i];
                            pos  = i;
                        end
                    end
                    drop_shadow_slot(pos);
                    ok = 1'b1;
                end
            end
        endcase
        res.success     = ok;
        res.entry_count = OUT_CNT_W'(shadow_fill);
        return res;
    endfunction

    // Send one item. Called at a rising edge; returns at the edge that accepted it,
    // with start still high so a back-to-back item can follow without a dip.
    task automatic send_item(
        input t_mode            mode,
        input logic [KEY_W-1:0] key,
        input logic [DIM_W-1:0] len,
        input logic [DIM_W-1:0] wid,
        input logic [DIM_W-1:0] hgt
    );
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_mode       <= mode;
        i_key        <= key;
        i_length_dim <= len;
        i_width_dim  <= wid;
        i_height_dim <= hgt;
        // Hold the item until an edge sees start high and busy low.
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        pending_outcomes.push_back(apply_table_op(mode, key, len, wid, hgt));
    endtask

    // Favor a few corner dimensions so that equal volumes and zero volumes turn up.
    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'h0100;
            2:       return '1;
            default: return DIM_W'($urandom());
        endcase
    endfunction

    // Pick a key held in the table with a chance of held_pct percent, else a fresh or tiny one.
    function automatic logic [KEY_W-1:0] pick_held_key(input int unsigned held_pct);
        if (shadow_fill > 0 && $urandom_range(0, 99) < held_pct) begin
            return shadow_keys[$urandom_range(0, shadow_fill - 1)];
        end
        if ($urandom_range(0, 9) == 0) begin
            return KEY_W'($urandom_range(0, 7));
        end
        return $urandom();
    endfunction

    // Compare every result against the oldest outstanding outcome.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: success=%0b count=%0d",
                                          o_success, o_entry_count));
            end else begin
                want = pending_outcomes.pop_front();
                if (o_success !== want.success) begin
                    report_mismatch($sformatf("success %0b, want %0b",
                                              o_success, want.success));
                end
                if (o_entry_count !== want.entry_count) begin
                    report_mismatch($sformatf("entry_count %0d, want %0d",
                                              o_entry_count, want.entry_count));
                end
            end
        end
    end

    // Walk every mode and every special case on a nearly empty table.
    task automatic test_directed();
        send_item(MODE_CLEAR,   32'h0,        16'h0,    16'h0,    16'h0);
        // Remove from an empty table: both removals must fail.
        send_item(MODE_REM_MIN, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(MODE_REM_KEY, 32'h0,        16'h0,    16'h0,    16'h0);
        // Extreme keys and extreme dimensions.
        send_item(MODE_INSERT,  32'h0,        16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(MODE_INSERT,  32'hFFFF_FFFF, 16'h0,    16'h0,    16'h0);
        // Duplicate key is refused.
        send_item(MODE_INSERT,  32'h0,        16'h0100, 16'h0100, 16'h0100);
        send_item(MODE_INSERT,  32'hA5A5_A5A5, 16'h0100, 16'h0100, 16'h0100);
        send_item(MODE_INSERT,  32'h5A5A_5A5A, 16'h0080, 16'h0200, 16'h0100);
        // Second zero volume at a higher index; the lower one must go first.
        send_item(MODE_INSERT,  32'h0000_0001, 16'h8000, 16'h0,    16'h1234);
        send_item(MODE_REM_MIN, 32'h0,        16'h0,    16'h0,    16'h0);
        send_item(MODE_REM_MIN, 32'h0,        16'h0,    16'h0,    16'h0);
        // Remove the last slot, then the same key again.
        send_item(MODE_REM_KEY, 32'hA5A5_A5A5, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(MODE_REM_KEY, 32'hA5A5_A5A5, 16'h0,    16'h0,    16'h0);
        // Remove the first slot so the last entry moves down.
        send_item(MODE_REM_KEY, 32'h0,        16'h0,    16'h0,    16'h0);
        send_item(MODE_REM_MIN, 32'h0,        16'h0,    16'h0,    16'h0);
        send_item(MODE_REM_MIN, 32'h0,        16'h0,    16'h0,    16'h0);
        // Clear a table that holds entries.
        send_item(MODE_INSERT,  32'h1234_5678, 16'h00FF, 16'h0001, 16'hFF00);
        send_item(MODE_INSERT,  32'h8765_4321, 16'h7FFF, 16'h8000, 16'h0001);
        send_item(MODE_CLEAR,   32'hDEAD_BEEF, 16'h1111, 16'h2222, 16'h3333);
        send_item(MODE_REM_KEY, 32'h1234_5678, 16'h0,    16'h0,    16'h0);
    endtask

    // Fill to capacity, hit the full-table refusal, then drain part of it.
    task automatic test_full_table();
        send_item(MODE_CLEAR, $urandom(), pick_dim(), pick_dim(), pick_dim());
        back_to_back = 1'b1;
        while (shadow_fill < CAPACITY) begin
            send_item(MODE_INSERT, $urandom(), pick_dim(), pick_dim(), pick_dim());
        end
        back_to_back = 1'b0;
        // Fresh keys and a duplicate are all refused while full; one removal then makes room again.
        send_item(MODE_INSERT, $urandom(), pick_dim(), pick_dim(), pick_dim());
        send_item(MODE_INSERT, $urandom(), pick_dim(), pick_dim(), pick_dim());
        send_item(MODE_INSERT, pick_held_key(100), pick_dim(), pick_dim(), pick_dim());
        send_item(MODE_REM_MIN, $urandom(), pick_dim(), pick_dim(), pick_dim());
        send_item(MODE_INSERT, $urandom(), pick_dim(), pick_dim(), pick_dim());
        // Drop the last slot of a full table, then try to remove a random, likely absent key.
        send_item(MODE_REM_KEY, shadow_keys[CAPACITY-1], pick_dim(), pick_dim(), pick_dim());
        send_item(MODE_REM_KEY, $urandom(), pick_dim(), pick_dim(), pick_dim());
        repeat (20) begin
            send_item(MODE_REM_MIN, $urandom(), pick_dim(), pick_dim(), pick_dim());
        end
        repeat (10) begin
            send_item(MODE_REM_KEY, pick_held_key(90), pick_dim(), pick_dim(), pick_dim());
        end
    endtask

    // Random mix; the insert share changes every 50 items so the fill
    // level wanders up and down, and some stretches run without gaps.
    task automatic test_random(input int unsigned num_items);
        int unsigned insert_pct;
        int unsigned roll;
        t_mode       mode;
        logic [KEY_W-1:0] key;
        insert_pct = 50;
        for (int n = 0; n < num_items; n++) begin
            if (n % 50 == 0) begin
                insert_pct   = $urandom_range(25, 75);
                back_to_back = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                mode = MODE_CLEAR;
                key  = $urandom();
            end else if (roll < 2 + insert_pct) begin
                mode = MODE_INSERT;
                key  = pick_held_key(20);
            end else if (roll < 2 + insert_pct + (98 - insert_pct) / 2) begin
                mode = MODE_REM_KEY;
                key  = pick_held_key(75);
            end else begin
                mode = MODE_REM_MIN;
                key  = $urandom();
            end
            send_item(mode, key, pick_dim(), pick_dim(), pick_dim());
        end
        back_to_back = 1'b0;
    endtask

    initial begin
        // Hold reset low from the start, then release it at a rising edge.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_random(550);

        start <= 1'b0;
        // Drain outstanding results, then watch for strays over one full scan.
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 16) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
